FILE: rtl/tpris_pkg.sv
// Shared types and constants for the two-phase relay impulse sequencer.
package tpris_pkg;

	localparam int HAND_STEPS  = 720;
	localparam int PLATE_STEPS = 64;
	localparam int HP_W        = 10;
	localparam int PP_W        = 6;
	localparam int TICK_W      = 16;
	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd3000;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_HAND  = 2'd1,
		FN_PLATE = 2'd2,
		FN_STOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ONE  = 2'd1,
		PH_TWO  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_HAND  = 2'd1,
		KIND_PLATE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]      func;
		logic [HP_W-1:0] start_position;
	} in_item_t;

	typedef struct packed {
		logic            accepted;
		logic            hand_even_relay;
		logic            hand_odd_relay;
		logic            plate_even_relay;
		logic            plate_odd_relay;
		logic [1:0]      phase_now;
		logic [1:0]      active_kind;
		logic            impulse_done;
		logic [HP_W-1:0] hand_position_now;
		logic [PP_W-1:0] plate_position_now;
	} out_item_t;

endpackage

FILE: rtl/tpris_if.sv
// Valid/ready channel interfaces for input and result transfers.
interface tpris_in_if;
	logic               valid;
	logic               ready;
	tpris_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tpris_out_if;
	logic                valid;
	logic                ready;
	tpris_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/two_phase_relay_impulse_sequencer_top.sv
// A result is captured in the output register on its input transfer.
// Throughput: one item per cycle; input ready stays high while the result register
// is empty or being taken in the same cycle.
// Reset: arst_n clears phase, kind, elapsed count and positions, loads phase_ticks
// with 3000 and empties the result register.
module two_phase_relay_impulse_sequencer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	tpris_in_if.sink                     in_ch,
	tpris_out_if.source                  out_ch,
	input  logic                         cfg_wr_en,
	input  logic [tpris_pkg::TICK_W-1:0] cfg_wr_data
);

	logic                 out_valid_q;
	tpris_pkg::out_item_t out_data_q;
	tpris_pkg::out_item_t result;
	logic                 step;

	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign step         = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	tpris_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (in_ch.data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

endmodule

FILE: rtl/tpris_core.sv
// Sequencer state and combinational next-state and result logic.
module tpris_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  tpris_pkg::in_item_t               item,
	input  logic                              cfg_wr_en,
	input  logic [tpris_pkg::TICK_W-1:0]      cfg_wr_data,
	output tpris_pkg::out_item_t              result
);

	tpris_pkg::phase_t                   phase_q, phase_d;
	tpris_pkg::kind_t                    kind_q, kind_d;
	logic [tpris_pkg::TICK_W-1:0]        elapsed_q, elapsed_d, elapsed_inc;
	logic [tpris_pkg::TICK_W-1:0]        phase_ticks_q;
	logic [tpris_pkg::HP_W-1:0]          hand_pos_q, hand_pos_d, hand_start, hand_next;
	logic [tpris_pkg::PP_W-1:0]          plate_pos_q, plate_pos_d, plate_start, plate_next;
	logic [tpris_pkg::PP_W-1:0]          plate_raw;
	logic                                acc, done, first, odd_on;

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;

	// start positions fit below twice the step count: one compare and subtract
	assign hand_start = ({1'b0, item.start_position} >= (tpris_pkg::HP_W+1)'(tpris_pkg::HAND_STEPS))
		? tpris_pkg::HP_W'({1'b0, item.start_position}
			- (tpris_pkg::HP_W+1)'(tpris_pkg::HAND_STEPS))
		: item.start_position;
	assign plate_raw   = item.start_position[tpris_pkg::PP_W-1:0];
	assign plate_start = ({1'b0, plate_raw} >= (tpris_pkg::PP_W+1)'(tpris_pkg::PLATE_STEPS))
		? tpris_pkg::PP_W'({1'b0, plate_raw} - (tpris_pkg::PP_W+1)'(tpris_pkg::PLATE_STEPS))
		: plate_raw;

	assign hand_next  = (hand_pos_q == tpris_pkg::HP_W'(tpris_pkg::HAND_STEPS - 1))
		? '0 : hand_pos_q + 1'b1;
	assign plate_next = ({1'b0, plate_pos_q} == (tpris_pkg::PP_W+1)'(tpris_pkg::PLATE_STEPS - 1))
		? '0 : plate_pos_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		kind_d      = kind_q;
		elapsed_d   = elapsed_q;
		hand_pos_d  = hand_pos_q;
		plate_pos_d = plate_pos_q;
		acc         = 1'b0;
		done        = 1'b0;
		case (item.func)
			tpris_pkg::FN_TICK: begin
				if (phase_q != tpris_pkg::PH_IDLE) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc >= phase_ticks_q) begin
						elapsed_d = '0;
						if (phase_q == tpris_pkg::PH_ONE) begin
							phase_d = tpris_pkg::PH_TWO;
						end else begin
							phase_d = tpris_pkg::PH_IDLE;
							done    = 1'b1;
							if (kind_q == tpris_pkg::KIND_HAND) begin
								hand_pos_d = hand_next;
							end else begin
								plate_pos_d = plate_next;
							end
						end
					end
				end
			end
			tpris_pkg::FN_HAND: begin
				if (phase_q == tpris_pkg::PH_IDLE) begin
					kind_d     = tpris_pkg::KIND_HAND;
					hand_pos_d = hand_start;
					phase_d    = tpris_pkg::PH_ONE;
					elapsed_d  = '0;
					acc        = 1'b1;
				end
			end
			tpris_pkg::FN_PLATE: begin
				if (phase_q == tpris_pkg::PH_IDLE) begin
					kind_d      = tpris_pkg::KIND_PLATE;
					plate_pos_d = plate_start;
					phase_d     = tpris_pkg::PH_ONE;
					elapsed_d   = '0;
					acc         = 1'b1;
				end
			end
			default: begin
				phase_d   = tpris_pkg::PH_IDLE;
				kind_d    = tpris_pkg::KIND_NONE;
				elapsed_d = '0;
			end
		endcase
	end

	// relay drive follows the updated state
	assign first  = (phase_d == tpris_pkg::PH_ONE);
	assign odd_on = (hand_pos_d[0] == 1'b0) == first;

	always_comb begin
		result                    = '0;
		result.accepted           = acc;
		result.impulse_done       = done;
		result.phase_now          = phase_d;
		result.active_kind        = kind_d;
		result.hand_position_now  = hand_pos_d;
		result.plate_position_now = plate_pos_d;
		if (phase_d != tpris_pkg::PH_IDLE) begin
			if (kind_d == tpris_pkg::KIND_HAND) begin
				result.hand_odd_relay  = odd_on;
				result.hand_even_relay = !odd_on;
			end else if (kind_d == tpris_pkg::KIND_PLATE) begin
				result.plate_even_relay = first;
				result.plate_odd_relay  = !first;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tpris_pkg::PH_IDLE;
			kind_q        <= tpris_pkg::KIND_NONE;
			elapsed_q     <= '0;
			hand_pos_q    <= '0;
			plate_pos_q   <= '0;
			phase_ticks_q <= tpris_pkg::PHASE_TICKS_RST;
		end else begin
			if (cfg_wr_en) begin
				phase_ticks_q <= cfg_wr_data;
			end
			if (step) begin
				phase_q     <= phase_d;
				kind_q      <= kind_d;
				elapsed_q   <= elapsed_d;
				hand_pos_q  <= hand_pos_d;
				plate_pos_q <= plate_pos_d;
			end
		end
	end

endmodule

FILE: rtl/tpris_checker.sv
// Port-level checks for the sequencer top, attached by bind.
module tpris_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input tpris_pkg::out_item_t out_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_one_relay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_data.hand_even_relay, out_data.hand_odd_relay,
			out_data.plate_even_relay, out_data.plate_odd_relay}))
		else $error("more than one relay driven");

	a_idle_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.phase_now == tpris_pkg::PH_IDLE |->
			!(out_data.hand_even_relay || out_data.hand_odd_relay
			|| out_data.plate_even_relay || out_data.plate_odd_relay))
		else $error("relay driven while idle");

	a_accept_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |-> out_data.phase_now == tpris_pkg::PH_ONE
			&& !out_data.impulse_done)
		else $error("accepted request not in first phase");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.impulse_done |-> out_data.phase_now == tpris_pkg::PH_IDLE
			&& (out_data.active_kind == tpris_pkg::KIND_HAND
			|| out_data.active_kind == tpris_pkg::KIND_PLATE))
		else $error("impulse end without idle phase");

endmodule

bind two_phase_relay_impulse_sequencer_top tpris_checker u_tpris_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

FILE: bench/tb_two_phase_relay_impulse_sequencer_top.sv
// Testbench for the relay impulse sequencer: directed and random traffic with a predictor.
module tb_two_phase_relay_impulse_sequencer_top;
	import tpris_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [TICK_W-1:0]   cfg_wr_data;

	tpris_in_if  in_ch ();
	tpris_out_if out_ch ();

	two_phase_relay_impulse_sequencer_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state
	logic [TICK_W-1:0] phase_len;
	phase_t            drive_phase;
	kind_t             drive_kind;
	logic [TICK_W-1:0] elapsed;
	logic [HP_W-1:0]   hand_pos;
	logic [PP_W-1:0]   plate_pos;

	out_item_t expected_drive_q[$];
	int        mismatch_count;
	int        send_idle_pct;
	int        recv_stall_pct;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic out_item_t advance_sequencer(in_item_t it);
		out_item_t r;
		logic      first_phase;
		logic      odd_on;
		r = '0;
		case (it.func)
			FN_TICK: begin
				if (drive_phase != PH_IDLE) begin
					if (elapsed != 16'hFFFF)
						elapsed = elapsed + 1'b1;
					if (elapsed >= phase_len) begin
						elapsed = '0;
						if (drive_phase == PH_ONE) begin
							drive_phase = PH_TWO;
						end else begin
							drive_phase = PH_IDLE;
							if (drive_kind == KIND_HAND)
								hand_pos = HP_W'((int'(hand_pos) + 1) % HAND_STEPS);
							else
								plate_pos = PP_W'((int'(plate_pos) + 1) % PLATE_STEPS);
							r.impulse_done = 1'b1;
						end
					end
				end
			end
			FN_HAND: begin
				if (drive_phase == PH_IDLE) begin
					drive_kind  = KIND_HAND;
					hand_pos    = HP_W'(int'(it.start_position) % HAND_STEPS);
					drive_phase = PH_ONE;
					elapsed     = '0;
					r.accepted  = 1'b1;
				end
			end
			FN_PLATE: begin
				if (drive_phase == PH_IDLE) begin
					drive_kind  = KIND_PLATE;
					plate_pos   = PP_W'(int'(it.start_position[PP_W-1:0]) % PLATE_STEPS);
					drive_phase = PH_ONE;
					elapsed     = '0;
					r.accepted  = 1'b1;
				end
			end
			default: begin
				drive_phase = PH_IDLE;
				drive_kind  = KIND_NONE;
				elapsed     = '0;
			end
		endcase
		if (drive_phase != PH_IDLE) begin
			first_phase = (drive_phase == PH_ONE);
			if (drive_kind == KIND_HAND) begin
				// even position fires the odd relay first
				odd_on = ((hand_pos[0] == 1'b0) == first_phase);
				r.hand_odd_relay  = odd_on;
				r.hand_even_relay = !odd_on;
			end else if (drive_kind == KIND_PLATE) begin
				r.plate_even_relay = first_phase;
				r.plate_odd_relay  = !first_phase;
			end
		end
		r.phase_now          = drive_phase;
		r.active_kind        = drive_kind;
		r.hand_position_now  = hand_pos;
		r.plate_position_now = plate_pos;
		return r;
	endfunction

	task automatic check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			if (mismatch_count < 10)
				$display("mismatch %s: expected %0d, got %0d at %0t", name, exp_val, act_val,
					$realtime);
			mismatch_count++;
		end
	endtask

	// result checker and expectation capture, both sampled at the rising edge
	always @(posedge clk) begin
		out_item_t exp_r;
		out_item_t act_r;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				act_r = out_ch.data;
				if (expected_drive_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result transfer at %0t", $realtime);
					mismatch_count++;
				end else begin
					exp_r = expected_drive_q.pop_front();
					check_field("accepted", int'(exp_r.accepted), int'(act_r.accepted));
					check_field("hand_even_relay", int'(exp_r.hand_even_relay),
						int'(act_r.hand_even_relay));
					check_field("hand_odd_relay", int'(exp_r.hand_odd_relay),
						int'(act_r.hand_odd_relay));
					check_field("plate_even_relay", int'(exp_r.plate_even_relay),
						int'(act_r.plate_even_relay));
					check_field("plate_odd_relay", int'(exp_r.plate_odd_relay),
						int'(act_r.plate_odd_relay));
					check_field("phase_now", int'(exp_r.phase_now), int'(act_r.phase_now));
					check_field("active_kind", int'(exp_r.active_kind),
						int'(act_r.active_kind));
					check_field("impulse_done", int'(exp_r.impulse_done),
						int'(act_r.impulse_done));
					check_field("hand_position_now", int'(exp_r.hand_position_now),
						int'(act_r.hand_position_now));
					check_field("plate_position_now", int'(exp_r.plate_position_now),
						int'(act_r.plate_position_now));
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_drive_q.push_back(advance_sequencer(in_ch.data));
		end
	end

	always @(negedge clk) begin
		out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(func_t f, logic [HP_W-1:0] pos);
		in_item_t it;
		it.func           = f;
		it.start_position = pos;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_drive_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_phase_ticks(logic [TICK_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		phase_len = v;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// default phase length: rejects while busy, stop mid-impulse, idle ticks
	task automatic test_reset_state;
		send_item(FN_TICK, 10'd0);
		send_item(FN_HAND, 10'd0);
		send_item(FN_TICK, 10'd1023);
		send_item(FN_PLATE, 10'd5);
		send_item(FN_HAND, 10'd3);
		send_item(FN_STOP, 10'd0);
		send_item(FN_TICK, 10'd0);
		send_item(FN_PLATE, 10'd1023);
		send_item(FN_STOP, 10'd1023);
	endtask

	// position wrap, out-of-range starts, zero phase length
	task automatic test_edge_positions;
		write_phase_ticks(16'd1);
		send_item(FN_HAND, 10'd719);
		send_item(FN_TICK, 10'd0);
		send_item(FN_TICK, 10'd0);
		send_item(FN_HAND, 10'd1023);
		send_item(FN_TICK, 10'd0);
		send_item(FN_TICK, 10'd0);
		send_item(FN_PLATE, 10'd63);
		send_item(FN_TICK, 10'd0);
		send_item(FN_TICK, 10'd0);
		write_phase_ticks(16'd0);
		send_item(FN_HAND, 10'd720);
		send_item(FN_TICK, 10'd0);
		send_item(FN_PLATE, 10'd7);
		send_item(FN_TICK, 10'd0);
		send_item(FN_PLATE, 10'd0);
		send_item(FN_TICK, 10'd0);
		send_item(FN_STOP, 10'd0);
	endtask

	task automatic test_random_traffic(int n_items);
		int sent;
		int r;
		int n_ticks;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(99);
			if (r < 75) begin
				send_item($urandom_range(1) ? FN_HAND : FN_PLATE, 10'($urandom_range(1023)));
				sent++;
				n_ticks = 2 * ((phase_len == 0) ? 1 : int'(phase_len)) + $urandom_range(2);
				for (int i = 0; i < n_ticks; i++) begin
					r = $urandom_range(99);
					if (r < 6)
						send_item($urandom_range(1) ? FN_HAND : FN_PLATE,
							10'($urandom_range(1023)));
					else if (r < 8)
						send_item(FN_STOP, 10'($urandom_range(1023)));
					else
						send_item(FN_TICK, 10'($urandom_range(1023)));
					sent++;
				end
			end else begin
				send_item(func_t'($urandom_range(3)), 10'($urandom_range(1023)));
				sent++;
			end
		end
	endtask

	task automatic test_phase_lengths;
		for (int k = 0; k < 3; k++) begin
			write_phase_ticks(16'($urandom_range(6)));
			test_random_traffic(105);
		end
	endtask

	// longest phase length: plate impulse held in its first phase, request rejected, stop
	task automatic test_max_phase;
		write_phase_ticks(16'hFFFF);
		send_item(FN_PLATE, 10'($urandom_range(1023)));
		for (int i = 0; i < 16; i++)
			send_item(FN_TICK, 10'($urandom_range(1023)));
		send_item(FN_HAND, 10'($urandom_range(1023)));
		send_item(FN_STOP, 10'($urandom_range(1023)));
	endtask

	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.data     = '0;
		out_ch.ready   = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		mismatch_count = 0;
		phase_len      = PHASE_TICKS_RST;
		drive_phase    = PH_IDLE;
		drive_kind     = KIND_NONE;
		elapsed        = '0;
		hand_pos       = '0;
		plate_pos      = '0;
		set_idling(8, 57);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_edge_positions();
		test_phase_lengths();
		set_idling(57, 8);
		test_phase_lengths();
		set_idling(0, 0);
		test_max_phase();
		test_phase_lengths();
		drain();

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
